[rtl/scf_pkg.sv]
// Shared types and constants for the scroll follow controller.
// No dependencies; used by every module under rtl/.
`default_nettype none

package scf_pkg;

   localparam int POS_BITS_DEFAULT = 16;
   localparam int OFFSET_BITS      = 16;
   localparam int SPEED_BITS       = 5;
   localparam int WIDTH_BITS       = 11;
   localparam int THRESH_BITS      = 8;
   localparam int MAX_SPEED_BITS   = 4;
   localparam int PERIOD_BITS      = 4;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = 11;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FAST_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLOW_THRESHOLD = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_SPEED      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UPDATE_PERIOD  = 3'd4;

   // Reset values
   localparam logic [WIDTH_BITS-1:0]     SCREEN_WIDTH_RST   = 11'd384;
   localparam logic [THRESH_BITS-1:0]    FAST_THRESHOLD_RST = 8'd16;
   localparam logic [THRESH_BITS-1:0]    SLOW_THRESHOLD_RST = 8'd8;
   localparam logic [MAX_SPEED_BITS-1:0] MAX_SPEED_RST      = 4'd3;
   localparam logic [PERIOD_BITS-1:0]    UPDATE_PERIOD_RST  = 4'd2;

   typedef struct packed {
      logic [WIDTH_BITS-1:0]     screen_width;
      logic [THRESH_BITS-1:0]    fast_threshold;
      logic [THRESH_BITS-1:0]    slow_threshold;
      logic [MAX_SPEED_BITS-1:0] max_speed;
      logic [PERIOD_BITS-1:0]    update_period;
   } cfg_type;

endpackage

`default_nettype wire

[rtl/scf_csr.sv]
// Configuration register file of the scroll follow controller.
// Depends on scf_pkg for register indexes, reset values and cfg_type.
`default_nettype none

module scf_csr (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_valid,
   input  wire                                   csr_ready,
   input  wire  [scf_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire  [scf_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   output scf_pkg::cfg_type                      cfg
);

   scf_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width   <= scf_pkg::SCREEN_WIDTH_RST;
         cfg_ff.fast_threshold <= scf_pkg::FAST_THRESHOLD_RST;
         cfg_ff.slow_threshold <= scf_pkg::SLOW_THRESHOLD_RST;
         cfg_ff.max_speed      <= scf_pkg::MAX_SPEED_RST;
         cfg_ff.update_period  <= scf_pkg::UPDATE_PERIOD_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            scf_pkg::CSR_SCREEN_WIDTH:
               cfg_ff.screen_width <= csr_wdata[scf_pkg::WIDTH_BITS-1:0];
            scf_pkg::CSR_FAST_THRESHOLD:
               cfg_ff.fast_threshold <= csr_wdata[scf_pkg::THRESH_BITS-1:0];
            scf_pkg::CSR_SLOW_THRESHOLD:
               cfg_ff.slow_threshold <= csr_wdata[scf_pkg::THRESH_BITS-1:0];
            scf_pkg::CSR_MAX_SPEED:
               cfg_ff.max_speed <= csr_wdata[scf_pkg::MAX_SPEED_BITS-1:0];
            scf_pkg::CSR_UPDATE_PERIOD:
               cfg_ff.update_period <= csr_wdata[scf_pkg::PERIOD_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[rtl/scf_core.sv]
// Per-tick state update: divider, target, edge handling, speed ramp, offset.
// Depends on scf_pkg; state registers double as the result register.
`default_nettype none

module scf_core #(
   parameter int POS_BITS = scf_pkg::POS_BITS_DEFAULT
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    step,
   input  wire  signed [POS_BITS-1:0]             pos_a,
   input  wire  signed [POS_BITS-1:0]             pos_b,
   input  wire  scf_pkg::cfg_type                 cfg,
   output logic signed [scf_pkg::OFFSET_BITS-1:0] view_offset,
   output logic signed [scf_pkg::SPEED_BITS-1:0]  view_speed
);

   localparam int OB = scf_pkg::OFFSET_BITS;
   localparam int SB = scf_pkg::SPEED_BITS;
   localparam int WB = scf_pkg::WIDTH_BITS;
   localparam int TB = scf_pkg::THRESH_BITS;
   localparam int MB = scf_pkg::MAX_SPEED_BITS;
   localparam int PB = scf_pkg::PERIOD_BITS;
   // wide enough for target, offset and screen width with headroom
   localparam int EW = ((POS_BITS > OB) ? POS_BITS : OB) + 3;

   logic signed [OB-1:0]       offset_ff, offset_in;
   logic signed [SB-1:0]       speed_ff, speed_in;
   logic [PB-1:0]              tick_ff, tick_in;
   logic signed [POS_BITS-1:0] target_ff, target_in;
   logic                       hyst_ff, hyst_in;

   logic signed [POS_BITS:0]   pos_sum;
   logic signed [EW-1:0]       target_x, center_x, width_x, offset_x, thresh_x;
   logic signed [EW-1:0]       rel_x, err_x;
   logic signed [SB:0]         speed_x, max_x;
   logic signed [OB-1:0]       offset_adj;
   logic                       do_update;

   always_comb begin
      // floor of the midpoint equals min + (|a - b| >> 1)
      pos_sum   = {pos_a[POS_BITS-1], pos_a} + {pos_b[POS_BITS-1], pos_b};
      target_in = target_ff;
      do_update = (tick_ff >= cfg.update_period);
      if (do_update && (pos_a != pos_b)) begin
         target_in = pos_sum[POS_BITS:1];
      end

      target_x = {{(EW-POS_BITS){target_in[POS_BITS-1]}}, target_in};
      center_x = {{(EW-WB+1){1'b0}}, cfg.screen_width[WB-1:1]};
      width_x  = {{(EW-WB){1'b0}}, cfg.screen_width};
      offset_x = {{(EW-OB){offset_ff[OB-1]}}, offset_ff};
      thresh_x = {{(EW-TB){1'b0}},
                  (hyst_ff ? cfg.slow_threshold : cfg.fast_threshold)};
      rel_x    = target_x - center_x;
      err_x    = rel_x + offset_x;
      speed_x  = {speed_ff[SB-1], speed_ff};
      max_x    = {{(SB+1-MB){1'b0}}, cfg.max_speed};

      tick_in    = do_update ? '0 : tick_ff + {{(PB-1){1'b0}}, 1'b1};
      speed_in   = speed_ff;
      hyst_in    = hyst_ff;
      offset_adj = offset_ff;

      if (do_update) begin
         if (rel_x < 0) begin
            // past the left edge
            speed_in = '0;
            if (offset_ff < -16'sd1) offset_adj = offset_ff + 16'sd1;
         end else if (rel_x >= width_x) begin
            // past the right edge
            speed_in = '0;
            if (offset_x > (EW'(1) - width_x)) offset_adj = offset_ff - 16'sd1;
         end else if (err_x < -thresh_x) begin
            hyst_in = 1'b1;
            if (speed_x < 0 || speed_x < max_x) speed_in = speed_ff + 5'sd1;
         end else if (err_x > thresh_x) begin
            hyst_in = 1'b1;
            if (speed_x > 0 || speed_x > -max_x) speed_in = speed_ff - 5'sd1;
         end else begin
            hyst_in = 1'b0;
            if (speed_ff > 0)       speed_in   = speed_ff - 5'sd1;
            else if (speed_ff < 0)  speed_in   = speed_ff + 5'sd1;
            else if (err_x > 0)     offset_adj = offset_ff - 16'sd1;
            else if (err_x < 0)     offset_adj = offset_ff + 16'sd1;
         end
      end

      offset_in = offset_adj + {{(OB-SB){speed_in[SB-1]}}, speed_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         speed_ff  <= '0;
         tick_ff   <= '0;
         target_ff <= '0;
         hyst_ff   <= 1'b0;
      end else if (step) begin
         offset_ff <= offset_in;
         speed_ff  <= speed_in;
         tick_ff   <= tick_in;
         target_ff <= target_in;
         hyst_ff   <= hyst_in;
      end
   end

   assign view_offset = offset_ff;
   assign view_speed  = speed_ff;

endmodule

`default_nettype wire

[rtl/scroll_follow_controller_core.sv]
// Scroll follow controller: one result per accepted position pair.
// Request transfer loads the input register; the state/result register loads from it
// when the result stage advances. Throughput: one transfer per cycle while rsp_stall is
// low; the update between the registers is combinational. Synchronous active-high reset
// returns configuration to defaults, clears offset, speed, divider, target and
// hysteresis, and empties both stages. Depends on scf_pkg, scf_csr, scf_core.
`default_nettype none

module scroll_follow_controller_core #(
   parameter int POS_BITS = scf_pkg::POS_BITS_DEFAULT
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_valid,
   output logic                                    req_stall,
   input  wire  signed [POS_BITS-1:0]              req_first_position,
   input  wire  signed [POS_BITS-1:0]              req_second_position,
   output logic                                    rsp_valid,
   input  wire                                     rsp_stall,
   output logic signed [scf_pkg::OFFSET_BITS-1:0]  rsp_view_offset,
   output logic signed [scf_pkg::SPEED_BITS-1:0]   rsp_view_speed,
   input  wire                                     csr_valid,
   output logic                                    csr_ready,
   input  wire  [scf_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  wire  [scf_pkg::CSR_DATA_BITS-1:0]       csr_wdata
);

   scf_pkg::cfg_type           cfg;
   logic                       in_valid_ff;
   logic signed [POS_BITS-1:0] pos_a_ff, pos_b_ff;
   logic                       rsp_valid_ff;
   logic                       advance, step;

   assign csr_ready = 1'b1;

   // the result stage frees up when empty or when its transfer completes
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) in_valid_ff <= req_valid;
         if (advance)    rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         pos_a_ff <= req_first_position;
         pos_b_ff <= req_second_position;
      end
   end

   scf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   scf_core #(
      .POS_BITS (POS_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .pos_a       (pos_a_ff),
      .pos_b       (pos_b_ff),
      .cfg         (cfg),
      .view_offset (rsp_view_offset),
      .view_speed  (rsp_view_speed)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire
